[src/iac_pkg.sv]
// Shared types and constants for the intrusion alarm controller.
// Used by iac_csr, iac_core and intrusion_alarm_controller; no dependencies.
package iac_pkg;

   // Item kinds
   localparam logic [2:0] KIND_TICK   = 3'd0;
   localparam logic [2:0] KIND_OK     = 3'd1;
   localparam logic [2:0] KIND_PLUS   = 3'd2;
   localparam logic [2:0] KIND_MINUS  = 3'd3;
   localparam logic [2:0] KIND_CANCEL = 3'd4;

   // Panel modes
   localparam logic [2:0] MODE_DISARMED = 3'd0;
   localparam logic [2:0] MODE_EXIT     = 3'd1;
   localparam logic [2:0] MODE_ARMED    = 3'd2;
   localparam logic [2:0] MODE_ENTRY    = 3'd3;
   localparam logic [2:0] MODE_SOUND    = 3'd4;

   // Drive bit positions
   localparam int DRV_SIREN  = 0;
   localparam int DRV_LIGHTS = 1;
   localparam int DRV_GREEN  = 2;
   localparam int DRV_RED    = 3;

   // Register indexes
   localparam int          CsrAddrW = 3;
   localparam int          CsrDataW = 16;
   localparam logic [CsrAddrW-1:0] REG_PIN_CODE     = 3'd0;
   localparam logic [CsrAddrW-1:0] REG_DELAY_SEC    = 3'd1;
   localparam logic [CsrAddrW-1:0] REG_TICKS_PER_S  = 3'd2;
   localparam logic [CsrAddrW-1:0] REG_POLL_TICKS   = 3'd3;
   localparam logic [CsrAddrW-1:0] REG_BLINK_TICKS  = 3'd4;
   localparam logic [CsrAddrW-1:0] REG_SIREN_TICKS  = 3'd5;

   // Register reset values
   localparam logic [7:0]  RST_DELAY_SEC   = 8'd60;
   localparam logic [7:0]  RST_TICKS_PER_S = 8'd100;
   localparam logic [7:0]  RST_POLL_TICKS  = 8'd50;
   localparam logic [7:0]  RST_BLINK_TICKS = 8'd50;
   localparam logic [15:0] RST_SIREN_TICKS = 16'd12000;

   localparam int NumDigits = 4;

   typedef struct packed {
      logic [7:0]  pin_code;
      logic [7:0]  delay_seconds;
      logic [7:0]  ticks_per_second;
      logic [7:0]  poll_ticks;
      logic [7:0]  blink_ticks;
      logic [15:0] siren_ticks;
   } cfg_type;

   typedef struct packed {
      logic       red_led;
      logic       green_led;
      logic       lights_on;
      logic       siren_on;
      logic [1:0] entry_digit;
      logic [2:0] entry_position;
      logic [7:0] seconds_left;
      logic [2:0] mode;
   } rsp_type;

endpackage

[src/intrusion_alarm_controller.sv]
// Intrusion alarm panel: one result per item (tick or button press), giving
// the panel state after that item. An item goes through an input register and
// the panel update into the result register, which offers its result. One item
// is taken every cycle while rsp_tready is high; only the result register's
// handshake slows the stream. Configuration writes are taken on any cycle but
// must only be made while no item is in flight.
// Depends on iac_pkg, iac_csr and iac_core.
module intrusion_alarm_controller (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,  // [0] door_open
   input  logic [2:0]                    req_tuser,  // [2:0] kind
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [2:0] mode, [10:3] seconds_left, [13:11] entry_position, [15:14] entry_digit,
   // [16] siren_on, [17] lights_on, [18] green_led, [19] red_led
   output logic [23:0]                   rsp_tdata,
   input  logic                          csr_we,
   input  logic [iac_pkg::CsrAddrW-1:0]  csr_addr,
   input  logic [iac_pkg::CsrDataW-1:0]  csr_wdata
);
   import iac_pkg::*;

   cfg_type    cfg;
   rsp_type    result;
   logic       in_valid_ff;
   logic [2:0] kind_ff;
   logic       door_ff;
   logic       rsp_valid_ff;
   rsp_type    rsp_data_ff;
   logic       advance;
   logic       step_en;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign step_en    = in_valid_ff && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         kind_ff <= req_tuser;
         door_ff <= req_tdata[0];
      end
   end

   iac_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   iac_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step_en   (step_en),
      .kind      (kind_ff),
      .door_open (door_ff),
      .cfg       (cfg),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_data_ff};

endmodule

[src/iac_csr.sv]
// Configuration register bank of the intrusion alarm controller.
// Depends on iac_pkg.
module iac_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [iac_pkg::CsrAddrW-1:0]  csr_addr,
   input  logic [iac_pkg::CsrDataW-1:0]  csr_wdata,
   output iac_pkg::cfg_type              cfg
);
   import iac_pkg::*;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pin_code         <= '0;
         cfg_ff.delay_seconds    <= RST_DELAY_SEC;
         cfg_ff.ticks_per_second <= RST_TICKS_PER_S;
         cfg_ff.poll_ticks       <= RST_POLL_TICKS;
         cfg_ff.blink_ticks      <= RST_BLINK_TICKS;
         cfg_ff.siren_ticks      <= RST_SIREN_TICKS;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_PIN_CODE:    cfg_ff.pin_code         <= csr_wdata[7:0];
            REG_DELAY_SEC:   cfg_ff.delay_seconds    <= csr_wdata[7:0];
            REG_TICKS_PER_S: cfg_ff.ticks_per_second <= csr_wdata[7:0];
            REG_POLL_TICKS:  cfg_ff.poll_ticks       <= csr_wdata[7:0];
            REG_BLINK_TICKS: cfg_ff.blink_ticks      <= csr_wdata[7:0];
            REG_SIREN_TICKS: cfg_ff.siren_ticks      <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

[src/iac_core.sv]
// Panel state and its combinational update for one item.
// Depends on iac_pkg; configuration comes from iac_csr.
module iac_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             step_en,
   input  logic [2:0]       kind,
   input  logic             door_open,
   input  iac_pkg::cfg_type cfg,
   output iac_pkg::rsp_type result
);
   import iac_pkg::*;

   logic [2:0]  mode_ff,    mode_in;
   logic [7:0]  seconds_ff, seconds_in;
   logic [7:0]  sec_div_ff, sec_div_in;
   logic [7:0]  poll_div_ff, poll_div_in;
   logic [7:0]  blink_div_ff, blink_div_in;
   logic [15:0] siren_cnt_ff, siren_cnt_in;
   logic [2:0]  pos_ff,     pos_in;
   logic [1:0]  digit_ff,   digit_in;
   logic [1:0]  digits_ff [NumDigits];
   logic [1:0]  digits_in [NumDigits];
   logic [3:0]  drive_ff,   drive_in;

   always_comb begin
      logic       entering;
      logic [3:0] toggle;
      logic       do_blink;
      logic       match;
      logic [1:0] back_idx;

      mode_in      = mode_ff;
      seconds_in   = seconds_ff;
      sec_div_in   = sec_div_ff;
      poll_div_in  = poll_div_ff;
      blink_div_in = blink_div_ff;
      siren_cnt_in = siren_cnt_ff;
      pos_in       = pos_ff;
      digit_in     = digit_ff;
      digits_in    = digits_ff;
      drive_in     = drive_ff;
      entering     = (mode_ff == MODE_ENTRY) || (mode_ff == MODE_SOUND);
      toggle       = '0;
      do_blink     = 1'b0;
      match        = 1'b0;
      back_idx     = pos_ff[1:0] - 2'd2;

      unique case (kind)
         KIND_TICK: begin
            if (mode_ff == MODE_ARMED) begin
               if (poll_div_ff == '0) begin
                  poll_div_in = cfg.poll_ticks;
                  if (door_open) begin
                     mode_in      = MODE_ENTRY;
                     seconds_in   = cfg.delay_seconds;
                     sec_div_in   = cfg.ticks_per_second;
                     blink_div_in = cfg.blink_ticks;
                     pos_in       = 3'd1;
                     digit_in     = '0;
                     for (int i = 0; i < NumDigits; i++) digits_in[i] = '0;
                  end
               end else begin
                  poll_div_in = poll_div_ff - 8'd1;
               end
            end else if (mode_ff == MODE_SOUND) begin
               if (siren_cnt_ff == '0) begin
                  drive_in[DRV_SIREN]  = 1'b0;
                  drive_in[DRV_LIGHTS] = 1'b0;
                  do_blink = 1'b1;
                  toggle[DRV_GREEN] = 1'b1;
                  toggle[DRV_RED]   = 1'b1;
               end else begin
                  siren_cnt_in = siren_cnt_ff - 16'd1;
               end
            end else if (mode_ff == MODE_EXIT || mode_ff == MODE_ENTRY) begin
               do_blink = 1'b1;
               if (mode_ff == MODE_EXIT) toggle[DRV_GREEN] = 1'b1;
               else                      toggle[DRV_RED]   = 1'b1;
            end

            // blink divider step, shared by countdown and post-siren blinking
            if (do_blink) begin
               if (blink_div_ff == '0) begin
                  drive_in     = drive_in ^ toggle;
                  blink_div_in = cfg.blink_ticks;
               end else begin
                  blink_div_in = blink_div_ff - 8'd1;
               end
            end

            if (mode_ff == MODE_EXIT || mode_ff == MODE_ENTRY) begin
               if (sec_div_ff == '0) begin
                  seconds_in = seconds_ff - 8'd1;
                  sec_div_in = cfg.ticks_per_second;
                  if (seconds_in == '0) begin
                     if (mode_ff == MODE_EXIT) begin
                        mode_in     = MODE_ARMED;
                        poll_div_in = cfg.poll_ticks;
                        drive_in    = '0;
                        drive_in[DRV_RED] = 1'b1;
                     end else begin
                        mode_in      = MODE_SOUND;
                        siren_cnt_in = cfg.siren_ticks;
                        blink_div_in = cfg.blink_ticks;
                        drive_in[DRV_SIREN]  = 1'b1;
                        drive_in[DRV_LIGHTS] = 1'b1;
                     end
                  end
               end else begin
                  sec_div_in = sec_div_ff - 8'd1;
               end
            end
         end
         KIND_OK: begin
            if (mode_ff == MODE_DISARMED) begin
               mode_in      = MODE_EXIT;
               seconds_in   = cfg.delay_seconds;
               sec_div_in   = cfg.ticks_per_second;
               blink_div_in = cfg.blink_ticks;
            end else if (entering) begin
               if (pos_ff >= 3'd1 && pos_ff <= 3'd3) begin
                  digits_in[pos_ff[1:0] - 2'd1] = digit_ff;
                  pos_in = pos_ff + 3'd1;
               end else if (pos_ff == 3'd4) begin
                  digits_in[NumDigits-1] = digit_ff;
                  match = 1'b1;
                  for (int k = 0; k < NumDigits; k++) begin
                     if (digits_in[k] != cfg.pin_code[2*k +: 2]) match = 1'b0;
                  end
                  if (match) begin
                     mode_in    = MODE_DISARMED;
                     seconds_in = '0;
                     pos_in     = '0;
                     digit_in   = '0;
                     drive_in   = '0;
                     drive_in[DRV_GREEN] = 1'b1;
                  end
               end
            end
         end
         KIND_PLUS: begin
            if (entering) digit_in = digit_ff + 2'd1;
         end
         KIND_MINUS: begin
            if (entering) digit_in = digit_ff - 2'd1;
         end
         KIND_CANCEL: begin
            if (entering) begin
               // step back one digit and recall what was stored there
               if (pos_ff > 3'd1 && pos_ff <= 3'd4) begin
                  pos_in   = pos_ff - 3'd1;
                  digit_in = digits_ff[back_idx];
               end
            end else if (mode_ff == MODE_EXIT) begin
               mode_in    = MODE_DISARMED;
               seconds_in = '0;
               pos_in     = '0;
               digit_in   = '0;
               drive_in   = '0;
               drive_in[DRV_GREEN] = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_DISARMED;
         seconds_ff   <= '0;
         sec_div_ff   <= '0;
         poll_div_ff  <= '0;
         blink_div_ff <= '0;
         siren_cnt_ff <= '0;
         pos_ff       <= '0;
         digit_ff     <= '0;
         for (int i = 0; i < NumDigits; i++) digits_ff[i] <= '0;
         drive_ff     <= 4'b0100;
      end else if (step_en) begin
         mode_ff      <= mode_in;
         seconds_ff   <= seconds_in;
         sec_div_ff   <= sec_div_in;
         poll_div_ff  <= poll_div_in;
         blink_div_ff <= blink_div_in;
         siren_cnt_ff <= siren_cnt_in;
         pos_ff       <= pos_in;
         digit_ff     <= digit_in;
         digits_ff    <= digits_in;
         drive_ff     <= drive_in;
      end
   end

   // result reflects the state after the item
   always_comb begin
      result.mode           = mode_in;
      result.seconds_left   = seconds_in;
      result.entry_position = pos_in;
      result.entry_digit    = digit_in;
      result.siren_on       = drive_in[DRV_SIREN];
      result.lights_on      = drive_in[DRV_LIGHTS];
      result.green_led      = drive_in[DRV_GREEN];
      result.red_led        = drive_in[DRV_RED];
   end

endmodule
